// File: rtl/gcd_pkg.sv
package gcd_pkg;

    localparam int NUM_DENOMS = 12;
    localparam int VALUE_BITS = 13;
    localparam int COUNT_BITS = 8;
    localparam int REM_BITS   = 13;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [REM_BITS-1:0]   rem_t;

    localparam value_t FIRST_DENOM = 13'd5000;

    localparam value_t DENOMS [NUM_DENOMS] = '{
        13'd5000, 13'd2000, 13'd1000, 13'd500, 13'd200, 13'd100,
        13'd50,   13'd20,   13'd10,   13'd5,   13'd2,   13'd1
    };

    // token, remainder and carried count passed from cell to cell
    typedef struct packed {
        logic   tok;
        rem_t   rem;
        count_t cnt;
    } link_t;

    // one result word, all zero when not valid so sources can be or-ed
    typedef struct packed {
        logic   vld;
        value_t value;
        count_t count;
        logic   invalid;
        logic   last;
    } res_t;

endpackage

// File: rtl/gcd_in_if.sv
interface gcd_in_if #(
    parameter int AMOUNT_BITS = 20
);
    logic                   valid;
    logic                   ready;
    logic [AMOUNT_BITS-1:0] due_amount;
    logic [AMOUNT_BITS-1:0] paid_amount;

    modport source (output valid, output due_amount, output paid_amount, input ready);
    modport sink   (input valid, input due_amount, input paid_amount, output ready);
endinterface

// File: rtl/gcd_out_if.sv
interface gcd_out_if;
    logic                   valid;
    logic                   ready;
    logic [12:0]            coin_value;
    logic [7:0]             coin_count;
    logic                   invalid_payment;
    logic                   last_result;

    modport source (output valid, output coin_value, output coin_count,
                    output invalid_payment, output last_result, input ready);
    modport sink   (input valid, input coin_value, input coin_count,
                    input invalid_payment, input last_result, output ready);
endinterface

// File: rtl/gcd_front.sv
module gcd_front #(
    parameter int AB = 20
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           take,
    input  logic [AB-1:0]  due,
    input  logic [AB-1:0]  paid,
    output gcd_pkg::link_t link,
    output gcd_pkg::res_t  special
);

    localparam int CH    = (AB > 14) ? AB : 14;
    localparam int SHIFT = CH + 13;
    localparam int MB    = CH + 1;
    localparam int QB    = CH - 12;
    localparam int PW    = CH + MB;
    localparam int DW    = QB + 13;
    localparam int QW    = (QB + 1 > 8) ? QB + 1 : 9;
    localparam logic [63:0]   MAGIC_FULL = (64'd1 << SHIFT) / 64'(gcd_pkg::FIRST_DENOM);
    localparam logic [MB-1:0] MAGIC      = MAGIC_FULL[MB-1:0];
    localparam logic [13:0]   D14        = 14'(gcd_pkg::FIRST_DENOM);

    logic          v1_reg, v1_next;
    logic          v2_reg, v2_next;
    logic          v3_reg, v3_next;
    logic          v4_reg, v4_next;
    logic [CH-1:0] diff1_reg, diff2_reg, diff3_reg;
    logic          neg1_reg, zero1_reg;
    logic [PW-1:0] prod2_reg;
    logic [QB-1:0] q3_reg, q4_reg;
    logic [DW-1:0] qd3_reg;
    logic [13:0]   r4_reg;

    logic [CH-1:0] due_x, paid_x;
    logic          is_special;
    logic [QB-1:0] q_est;
    logic [DW-1:0] r_full;
    logic [13:0]   r_fix;
    logic [QB:0]   q_fix;
    logic [QW-1:0] q_wide;

    assign due_x      = CH'(due);
    assign paid_x     = CH'(paid);
    assign is_special = neg1_reg || zero1_reg;
    assign q_est      = prod2_reg[SHIFT +: QB];
    assign r_full     = DW'(diff3_reg) - qd3_reg;

    always_comb
    begin
        v1_next = take ? 1'b1 : (adv ? 1'b0 : v1_reg);
        v2_next = adv ? (v1_reg && !is_special) : v2_reg;
        v3_next = adv ? v2_reg : v3_reg;
        v4_next = adv ? v3_reg : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            diff1_reg <= paid_x - due_x;
            neg1_reg  <= paid_x < due_x;
            zero1_reg <= paid_x == due_x;
        end
        if (adv)
        begin
            // quotient estimate by reciprocal, low by at most one
            diff2_reg <= diff1_reg;
            prod2_reg <= PW'(diff1_reg) * PW'(MAGIC);
            diff3_reg <= diff2_reg;
            q3_reg    <= q_est;
            qd3_reg   <= DW'(q_est) * DW'(gcd_pkg::FIRST_DENOM);
            q4_reg    <= q3_reg;
            r4_reg    <= r_full[13:0];
        end
    end

    always_comb
    begin
        if (r4_reg >= D14)
        begin
            r_fix = r4_reg - D14;
            q_fix = {1'b0, q4_reg} + (QB+1)'(1);
        end
        else
        begin
            r_fix = r4_reg;
            q_fix = {1'b0, q4_reg};
        end
        q_wide   = QW'(q_fix);
        link.tok = v4_reg;
        link.rem = r_fix[gcd_pkg::REM_BITS-1:0];
        link.cnt = (|q_wide[QW-1:8]) ? 8'hFF : q_wide[7:0];
    end

    always_comb
    begin
        special         = '0;
        special.vld     = v1_reg && is_special;
        special.invalid = v1_reg && neg1_reg;
        special.last    = v1_reg && is_special;
    end

endmodule

// File: rtl/gcd_cell.sv
module gcd_cell #(
    parameter gcd_pkg::value_t DENOM = 13'd1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  gcd_pkg::link_t in_link,
    output gcd_pkg::link_t out_link,
    output gcd_pkg::res_t  res
);

    localparam logic [13:0] D1 = {1'b0, DENOM};
    localparam logic [13:0] D2 = {DENOM, 1'b0};

    logic            tok_reg, tok_next;
    gcd_pkg::rem_t   rem_reg;
    gcd_pkg::count_t cnt_reg;

    logic [13:0]     r14;
    logic [13:0]     r_after;
    logic [1:0]      q;
    gcd_pkg::count_t cnt;

    assign tok_next = adv ? in_link.tok : tok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg <= in_link.rem;
            cnt_reg <= in_link.cnt;
        end
    end

    // remainder below three times this denomination after the larger cells
    always_comb
    begin
        r14 = {1'b0, rem_reg};
        if (r14 >= D2)
        begin
            q       = 2'd2;
            r_after = r14 - D2;
        end
        else if (r14 >= D1)
        begin
            q       = 2'd1;
            r_after = r14 - D1;
        end
        else
        begin
            q       = 2'd0;
            r_after = r14;
        end
        cnt = cnt_reg + gcd_pkg::COUNT_BITS'(q);
    end

    always_comb
    begin
        out_link.tok = tok_reg && (r_after != '0);
        out_link.rem = r_after[gcd_pkg::REM_BITS-1:0];
        out_link.cnt = '0;
        res          = '0;
        if (tok_reg && (cnt != '0))
        begin
            res.vld   = 1'b1;
            res.value = DENOM;
            res.count = cnt;
            res.last  = (r_after == '0);
        end
    end

endmodule

// File: rtl/greedy_change_dispenser_core.sv
// greedy coin change over twelve denominations, 5000 down to 1 cent
//
// req carries due_amount and paid_amount; rsp returns one word per
// denomination with a nonzero count, largest first, last_result on the
// final one. an exact payment gives one word with value and count zero,
// an underpayment one word with invalid_payment set.
//
// one item is worked on at a time: req.ready drops on accept and rises as
// the item's last word enters the output register. an exact or short
// payment's word goes from the first front register straight into the
// output register; change words follow as a token walks the row of
// twelve cells, one denomination per cycle while rsp is not stalled.
// a three stage reciprocal multiply ahead of the row divides by 5000.
//
// a stalled rsp freezes the row and the front stages; the output register
// holds its word until taken. reset empties the pipeline and output
// register; no memory needs clearing.
module greedy_change_dispenser_core #(
    parameter int AMOUNT_BITS = 20
) (
    input  logic      clk,
    input  logic      rst_n,
    gcd_in_if.sink    req,
    gcd_out_if.source rsp
);

    localparam int N = gcd_pkg::NUM_DENOMS;

    logic          busy_reg, busy_next;
    logic          out_vld_reg, out_vld_next;
    gcd_pkg::res_t out_res_reg;

    logic           take;
    logic           adv;
    gcd_pkg::link_t links [N];
    gcd_pkg::res_t  cell_res [N];
    gcd_pkg::res_t  special;
    gcd_pkg::res_t  merged;

    assign take      = req.valid && !busy_reg;
    assign req.ready = !busy_reg;
    assign adv       = !(out_vld_reg && !rsp.ready);

    gcd_front #(
        .AB(AMOUNT_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .take    (take),
        .due     (req.due_amount),
        .paid    (req.paid_amount),
        .link    (links[0]),
        .special (special)
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        if (i < N - 1)
        begin : g_mid
            gcd_cell #(
                .DENOM(gcd_pkg::DENOMS[i])
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .in_link  (links[i]),
                .out_link (links[i+1]),
                .res      (cell_res[i])
            );
        end
        else
        begin : g_end
            gcd_cell #(
                .DENOM(gcd_pkg::DENOMS[i])
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .in_link  (links[i]),
                .out_link (),
                .res      (cell_res[i])
            );
        end
    end

    // at most one source holds a valid word in any cycle
    always_comb
    begin
        merged = special;
        for (int i = 0; i < N; i++)
        begin
            merged = gcd_pkg::res_t'(merged | cell_res[i]);
        end
    end

    always_comb
    begin
        out_vld_next = adv ? merged.vld : out_vld_reg;
        busy_next    = busy_reg;
        if (take)
        begin
            busy_next = 1'b1;
        end
        else if (adv && merged.vld && merged.last)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_res_reg <= merged;
        end
    end

    assign rsp.valid           = out_vld_reg;
    assign rsp.coin_value      = out_res_reg.value;
    assign rsp.coin_count      = out_res_reg.count;
    assign rsp.invalid_payment = out_res_reg.invalid;
    assign rsp.last_result     = out_res_reg.last;

endmodule

// File: rtl/gcd_checker.sv
module gcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [12:0] rsp_value,
    input logic [7:0]  rsp_count,
    input logic        rsp_invalid,
    input logic        rsp_last
);

    // a stalled word keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
            && $stable(rsp_count) && $stable(rsp_last) && $stable(rsp_invalid))
        else $error("rsp word changed while stalled");

    // only one item in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item accepted while busy");

    a_invalid_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_invalid |-> rsp_last && rsp_value == 13'd0 && rsp_count == 8'd0)
        else $error("bad underpayment word");

    a_change_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> rsp_value != 13'd0 && rsp_count != 8'd0 && !rsp_invalid)
        else $error("bad intermediate change word");

endmodule

bind greedy_change_dispenser_core gcd_checker u_gcd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_value   (rsp.coin_value),
    .rsp_count   (rsp.coin_count),
    .rsp_invalid (rsp.invalid_payment),
    .rsp_last    (rsp.last_result)
);
